[rtl/mdm_pkg.sv]
// Mecanum drive mixer package: field widths, register indexes, reset values,
// button bit positions and the per-wheel mixing helpers.
// No dependencies.
package mdm_pkg;

    localparam int ByteW  = 8;
    localparam int DutyW  = 7;
    localparam int IdxW   = 1;
    localparam int RotW   = ByteW + 1;   // trigger difference, -255..255
    localparam int SumW   = ByteW + 3;   // wheel sum, -509..509
    localparam int MagW   = SumW - 1;

    localparam logic [DutyW-1:0] MaxPwmReset   = DutyW'(60);
    localparam logic [DutyW-1:0] ClimbPwmReset = DutyW'(50);
    localparam logic [ByteW-1:0] StickCenter   = ByteW'(127);

    typedef enum logic [IdxW-1:0] {
        REG_MAX_PWM   = 1'b0,
        REG_CLIMB_PWM = 1'b1
    } reg_index_t;

    // button bit positions, highest wins
    localparam int BtnUpBoth    = 7;
    localparam int BtnUpFront   = 6;
    localparam int BtnUpRear    = 5;
    localparam int BtnDownBoth  = 4;
    localparam int BtnDownFront = 3;
    localparam int BtnDownRear  = 2;

    typedef struct packed {
        logic [DutyW-1:0] rev;
        logic [DutyW-1:0] fwd;
    } duty_pair_t;

    typedef struct packed {
        duty_pair_t lf;
        duty_pair_t rf;
        duty_pair_t lr;
        duty_pair_t rr;
        duty_pair_t front;
        duty_pair_t rear;
    } mix_result_t;

    // v*254/255 - 127: the floor of v*254/255 is v-1 for every v above zero
    function automatic logic signed [ByteW-1:0] map_stick(input logic [ByteW-1:0] v);
        logic [ByteW-1:0] scaled;
        scaled = (v == '0) ? '0 : v - ByteW'(1);
        return $signed(scaled - StickCenter);
    endfunction

    // symmetric clamp, then split into reverse / forward channel
    function automatic duty_pair_t drive_pair(input logic signed [SumW-1:0] v,
                                              input logic [DutyW-1:0] lim);
        logic [SumW-1:0] neg;
        logic [MagW-1:0] mag;
        logic [DutyW-1:0] duty;
        duty_pair_t p;
        neg  = SumW'(-v);
        mag  = v[SumW-1] ? neg[MagW-1:0] : v[MagW-1:0];
        duty = (mag > MagW'(lim)) ? lim : mag[DutyW-1:0];
        p.rev = v[SumW-1] ? duty : '0;
        p.fwd = v[SumW-1] ? '0 : duty;
        return p;
    endfunction

endpackage

[rtl/mecanum_drive_mixer_core.sv]
// An accepted transaction passes the input register, the mixing logic and the
// result register before its result shows on the out port.
// Throughput: one transaction per cycle while in_stall is low, and in_stall
// rises only when both registers are full and the downstream side stalls.
// Reset: clears both valid flags; max_pwm returns to 60, climb_pwm to 50.
// Depends on mdm_pkg.
module mecanum_drive_mixer_core
    import mdm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [DutyW-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [ByteW-1:0] joy_x,
    input  logic [ByteW-1:0] joy_y,
    input  logic [ByteW-1:0] trig_left,
    input  logic [ByteW-1:0] trig_right,
    input  logic [ByteW-1:0] buttons,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [DutyW-1:0] lf_rev,
    output logic [DutyW-1:0] lf_fwd,
    output logic [DutyW-1:0] rf_rev,
    output logic [DutyW-1:0] rf_fwd,
    output logic [DutyW-1:0] lr_rev,
    output logic [DutyW-1:0] lr_fwd,
    output logic [DutyW-1:0] rr_rev,
    output logic [DutyW-1:0] rr_fwd,
    output logic [DutyW-1:0] front_down,
    output logic [DutyW-1:0] front_up,
    output logic [DutyW-1:0] rear_down,
    output logic [DutyW-1:0] rear_up
);

    logic [DutyW-1:0] max_pwm_reg, climb_pwm_reg;

    logic             s1_valid_reg, s1_valid_next;
    logic [ByteW-1:0] jx_reg, jy_reg, tl_reg, tr_reg, btn_reg;
    logic             s2_valid_reg, s2_valid_next;
    mix_result_t      res_reg, res_next;

    logic s1_en, s2_en;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pwm_reg   <= MaxPwmReset;
            climb_pwm_reg <= ClimbPwmReset;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MAX_PWM:   max_pwm_reg   <= cfg_data;
                REG_CLIMB_PWM: climb_pwm_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign s2_en    = !s2_valid_reg || !out_stall;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;

    always_comb
    begin
        s1_valid_next = s1_en ? in_valid : s1_valid_reg;
        s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            jx_reg  <= joy_x;
            jy_reg  <= joy_y;
            tl_reg  <= trig_left;
            tr_reg  <= trig_right;
            btn_reg <= buttons;
        end
        if (s2_en && s1_valid_reg)
            res_reg <= res_next;
    end

    // ---------------- mixing ----------------
    logic signed [ByteW-1:0] vy, vx;
    logic signed [RotW-1:0]  rot;
    logic signed [SumW-1:0]  vx_w, vy_w, rot_w;
    logic front_raise, front_lower, rear_raise, rear_lower;

    always_comb
    begin
        vy    = map_stick(jx_reg);
        vx    = map_stick(jy_reg);
        rot   = $signed({1'b0, tl_reg}) - $signed({1'b0, tr_reg});
        vx_w  = SumW'(vx);
        vy_w  = SumW'(vy);
        rot_w = SumW'(rot);

        res_next.lf = drive_pair(vx_w + vy_w - rot_w, max_pwm_reg);
        res_next.rf = drive_pair(vx_w - vy_w + rot_w, max_pwm_reg);
        res_next.lr = drive_pair(vx_w - vy_w - rot_w, max_pwm_reg);
        res_next.rr = drive_pair(vx_w + vy_w + rot_w, max_pwm_reg);

        // climb priority encoder, bit 7 highest
        front_raise = 1'b0;
        front_lower = 1'b0;
        rear_raise  = 1'b0;
        rear_lower  = 1'b0;
        if (btn_reg[BtnUpBoth])
        begin
            front_raise = 1'b1;
            rear_raise  = 1'b1;
        end
        else if (btn_reg[BtnUpFront])
            front_raise = 1'b1;
        else if (btn_reg[BtnUpRear])
            rear_raise = 1'b1;
        else if (btn_reg[BtnDownBoth])
        begin
            front_lower = 1'b1;
            rear_lower  = 1'b1;
        end
        else if (btn_reg[BtnDownFront])
            front_lower = 1'b1;
        else if (btn_reg[BtnDownRear])
            rear_lower = 1'b1;

        res_next.front.rev = front_lower ? climb_pwm_reg : '0;
        res_next.front.fwd = front_raise ? climb_pwm_reg : '0;
        res_next.rear.rev  = rear_lower  ? climb_pwm_reg : '0;
        res_next.rear.fwd  = rear_raise  ? climb_pwm_reg : '0;
    end

    // ---------------- outputs ----------------
    assign out_valid  = s2_valid_reg;
    assign lf_rev     = res_reg.lf.rev;
    assign lf_fwd     = res_reg.lf.fwd;
    assign rf_rev     = res_reg.rf.rev;
    assign rf_fwd     = res_reg.rf.fwd;
    assign lr_rev     = res_reg.lr.rev;
    assign lr_fwd     = res_reg.lr.fwd;
    assign rr_rev     = res_reg.rr.rev;
    assign rr_fwd     = res_reg.rr.fwd;
    assign front_down = res_reg.front.rev;
    assign front_up   = res_reg.front.fwd;
    assign rear_down  = res_reg.rear.rev;
    assign rear_up    = res_reg.rear.fwd;

    // ---------------- assertions ----------------
    a_pair_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((lf_rev != '0 && lf_fwd != '0) || (rf_rev != '0 && rf_fwd != '0) ||
                        (lr_rev != '0 && lr_fwd != '0) || (rr_rev != '0 && rr_fwd != '0) ||
                        (front_down != '0 && front_up != '0) ||
                        (rear_down != '0 && rear_up != '0)))
        else $error("both channels of a bridge driven");

    a_wheel_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lf_rev <= max_pwm_reg && lf_fwd <= max_pwm_reg &&
                       rf_rev <= max_pwm_reg && rf_fwd <= max_pwm_reg &&
                       lr_rev <= max_pwm_reg && lr_fwd <= max_pwm_reg &&
                       rr_rev <= max_pwm_reg && rr_fwd <= max_pwm_reg))
        else $error("wheel duty above max_pwm");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && out_stall) |-> in_stall)
        else $error("input taken while pipeline blocked");

    a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s2_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an input transaction");

endmodule

[test/mecanum_drive_mixer_checker.sv]
`timescale 1ns / 1ps
// Checker for the mecanum drive mixer: it follows the register port and both channels,
// predicts the twelve duties of each accepted packet and compares them with the results.
// Depends on mdm_pkg.
module mecanum_drive_mixer_checker
    import mdm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [DutyW-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [ByteW-1:0] joy_x,
    input  logic [ByteW-1:0] joy_y,
    input  logic [ByteW-1:0] trig_left,
    input  logic [ByteW-1:0] trig_right,
    input  logic [ByteW-1:0] buttons,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [DutyW-1:0] lf_rev,
    input  logic [DutyW-1:0] lf_fwd,
    input  logic [DutyW-1:0] rf_rev,
    input  logic [DutyW-1:0] rf_fwd,
    input  logic [DutyW-1:0] lr_rev,
    input  logic [DutyW-1:0] lr_fwd,
    input  logic [DutyW-1:0] rr_rev,
    input  logic [DutyW-1:0] rr_fwd,
    input  logic [DutyW-1:0] front_down,
    input  logic [DutyW-1:0] front_up,
    input  logic [DutyW-1:0] rear_down,
    input  logic [DutyW-1:0] rear_up,
    output int               errors,
    output int               outstanding
);

    localparam int ReportLimit = 10;
    localparam int NumDuties   = 12;

    logic [DutyW-1:0] max_duty;
    logic [DutyW-1:0] climb_duty;
    mix_result_t      duties_due [$];

    string duty_names [NumDuties] = '{"lf_rev", "lf_fwd", "rf_rev", "rf_fwd",
                                      "lr_rev", "lr_fwd", "rr_rev", "rr_fwd",
                                      "front_down", "front_up", "rear_down", "rear_up"};

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    function automatic int stick_velocity(input logic [ByteW-1:0] v);
        return (int'(v) * 254) / 255 - 127;
    endfunction

    function automatic int clamp_wheel(input int v, input int lim);
        if (v >= lim)
            return lim;
        if (v <= -lim)
            return -lim;
        return v;
    endfunction

    // negative drives the reverse channel, zero or positive the forward one
    function automatic duty_pair_t split_drive(input int v);
        duty_pair_t p;
        if (v < 0)
        begin
            p.rev = DutyW'(-v);
            p.fwd = '0;
        end
        else
        begin
            p.rev = '0;
            p.fwd = DutyW'(v);
        end
        return p;
    endfunction

    function automatic mix_result_t mix_packet(input logic [ByteW-1:0] jx,
                                               input logic [ByteW-1:0] jy,
                                               input logic [ByteW-1:0] tl,
                                               input logic [ByteW-1:0] tr,
                                               input logic [ByteW-1:0] b,
                                               input int lim,
                                               input int cp);
        int          lateral;
        int          forward;
        int          spin;
        int          front_drive;
        int          rear_drive;
        mix_result_t r;
        lateral     = stick_velocity(jx);
        forward     = stick_velocity(jy);
        spin        = int'(tl) - int'(tr);
        front_drive = 0;
        rear_drive  = 0;
        r.lf = split_drive(clamp_wheel(forward + lateral - spin, lim));
        r.rf = split_drive(clamp_wheel(forward - lateral + spin, lim));
        r.lr = split_drive(clamp_wheel(forward - lateral - spin, lim));
        r.rr = split_drive(clamp_wheel(forward + lateral + spin, lim));
        // highest climb button wins, bits 1..0 do nothing
        if (b[BtnUpBoth])
        begin
            front_drive = cp;
            rear_drive  = cp;
        end
        else if (b[BtnUpFront])
            front_drive = cp;
        else if (b[BtnUpRear])
            rear_drive = cp;
        else if (b[BtnDownBoth])
        begin
            front_drive = -cp;
            rear_drive  = -cp;
        end
        else if (b[BtnDownFront])
            front_drive = -cp;
        else if (b[BtnDownRear])
            rear_drive = -cp;
        r.front = split_drive(front_drive);
        r.rear  = split_drive(rear_drive);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_duty   <= MaxPwmReset;
            climb_duty <= ClimbPwmReset;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_MAX_PWM:   max_duty   <= cfg_data;
                REG_CLIMB_PWM: climb_duty <= cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin : track
        logic [NumDuties*DutyW-1:0] seen;
        logic [NumDuties*DutyW-1:0] want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                duties_due.push_back(mix_packet(joy_x, joy_y, trig_left, trig_right, buttons,
                                                int'(max_duty), int'(climb_duty)));
            if (out_valid && !out_stall)
            begin
                seen = {lf_rev, lf_fwd, rf_rev, rf_fwd, lr_rev, lr_fwd, rr_rev, rr_fwd,
                        front_down, front_up, rear_down, rear_up};
                if (duties_due.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= ReportLimit)
                        $display("%0t: result transaction with nothing expected: %h", $realtime,
                                 seen);
                end
                else
                begin
                    want = duties_due.pop_front();
                    for (int i = 0; i < NumDuties; i++)
                    begin
                        if (seen[(NumDuties-1-i)*DutyW +: DutyW] !==
                            want[(NumDuties-1-i)*DutyW +: DutyW])
                        begin
                            errors = errors + 1;
                            if (errors <= ReportLimit)
                                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime,
                                         duty_names[i], want[(NumDuties-1-i)*DutyW +: DutyW],
                                         seen[(NumDuties-1-i)*DutyW +: DutyW]);
                        end
                    end
                end
            end
            outstanding <= duties_due.size();
        end
    end

endmodule

[test/mecanum_drive_mixer_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for mecanum_drive_mixer_core: drives joystick packets and register
// writes with random gaps and stalls, and gives the verdict from the checker's count.
// Depends on mdm_pkg, mecanum_drive_mixer_core and mecanum_drive_mixer_checker.
module mecanum_drive_mixer_core_tb;
    import mdm_pkg::*;

    localparam int Period     = 20;
    localparam int LongHold   = 80;
    localparam int Settle     = 3;
    localparam int StuckLimit = 1000;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_we     = 1'b0;
    logic [IdxW-1:0]  cfg_index  = '0;
    logic [DutyW-1:0] cfg_data   = '0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic [ByteW-1:0] joy_x      = '0;
    logic [ByteW-1:0] joy_y      = '0;
    logic [ByteW-1:0] trig_left  = '0;
    logic [ByteW-1:0] trig_right = '0;
    logic [ByteW-1:0] buttons    = '0;
    logic             out_valid;
    logic             out_stall  = 1'b1;
    logic [DutyW-1:0] lf_rev, lf_fwd, rf_rev, rf_fwd, lr_rev, lr_fwd, rr_rev, rr_fwd;
    logic [DutyW-1:0] front_down, front_up, rear_down, rear_up;
    int               errors;
    int               outstanding;
    int               stuck_cycles = 0;

    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit rx_hold_req = 1'b0;

    mecanum_drive_mixer_core dut (.*);

    mecanum_drive_mixer_checker checker_i (.*);

    always #(Period/2) clk = ~clk;

    // mostly no gap, often a short one, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ByteW-1:0] pick_byte();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            case ($urandom_range(0, 5))
                0: v = 0;
                1: v = 1;
                2: v = 127;
                3: v = 128;
                4: v = 254;
                default: v = 255;
            endcase
        end
        else if (r < 5)
            v = 104 + $urandom_range(0, 48);    // near center
        else
            v = $urandom_range(0, 255);
        return ByteW'(v);
    endfunction

    task automatic send_packet(input logic [ByteW-1:0] jx, input logic [ByteW-1:0] jy,
                               input logic [ByteW-1:0] tl, input logic [ByteW-1:0] tr,
                               input logic [ByteW-1:0] b);
        int n;
        n = tx_quiet ? 0 : idle_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid   <= 1'b1;
        joy_x      <= jx;
        joy_y      <= jy;
        trig_left  <= tl;
        trig_right <= tr;
        buttons    <= b;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random();
        logic [ByteW-1:0] tl;
        logic [ByteW-1:0] tr;
        logic [ByteW-1:0] b;
        int               v;
        int               r;
        tl = pick_byte();
        if ($urandom_range(0, 9) < 4)
        begin
            // triggers close together give small rotation
            v = int'(tl) + int'($urandom_range(0, 40)) - 20;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            tr = ByteW'(v);
        end
        else
            tr = pick_byte();
        r = $urandom_range(0, 9);
        if (r < 4)
            b = ByteW'(1 << $urandom_range(0, 7));
        else if (r == 4)
            b = '0;
        else
            b = ByteW'($urandom_range(0, 255));
        send_packet(pick_byte(), pick_byte(), tl, tr, b);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (Settle) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [DutyW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [DutyW-1:0] wheel_lim,
                              input logic [DutyW-1:0] climb_lim);
        drain();
        write_reg(REG_MAX_PWM, wheel_lim);
        write_reg(REG_CLIMB_PWM, climb_lim);
    endtask

    // receiver: random stalls, quiet stretches, and one long hold-off on request
    initial
    begin : receiver
        int n;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            out_stall <= 1'b0;
            repeat (1 + $urandom_range(0, 6)) @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                n = LongHold;
            end
            else if (rx_quiet)
                n = 0;
            else
                n = idle_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= StuckLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: 60 wheel, 50 climb
        send_packet(8'd0,   8'd0,   8'd0,   8'd0,   8'h00);
        send_packet(8'd255, 8'd255, 8'd255, 8'd255, 8'hFF);
        send_packet(8'd128, 8'd128, 8'd0,   8'd0,   8'h00);
        send_packet(8'd127, 8'd128, 8'd10,  8'd10,  8'h03);
        send_packet(8'd255, 8'd128, 8'd0,   8'd0,   8'h80);
        send_packet(8'd0,   8'd128, 8'd0,   8'd0,   8'h40);
        send_packet(8'd128, 8'd255, 8'd0,   8'd0,   8'h20);
        send_packet(8'd128, 8'd0,   8'd0,   8'd0,   8'h10);
        send_packet(8'd128, 8'd128, 8'd255, 8'd0,   8'h08);
        send_packet(8'd128, 8'd128, 8'd0,   8'd255, 8'h04);
        send_packet(8'd1,   8'd254, 8'd0,   8'd0,   8'hC0);
        send_packet(8'd128, 8'd128, 8'd5,   8'd0,   8'h1C);
        send_packet(8'd138, 8'd120, 8'd0,   8'd3,   8'h0C);
        send_packet(8'd128, 8'd188, 8'd0,   8'd0,   8'h24);
        send_packet(8'd128, 8'd189, 8'd0,   8'd0,   8'h00);
        send_packet(8'd128, 8'd187, 8'd0,   8'd0,   8'h00);
        send_packet(8'd0,   8'd0,   8'd255, 8'd0,   8'h01);
        send_packet(8'd255, 8'd255, 8'd0,   8'd255, 8'h02);
        send_packet(8'd200, 8'd60,  8'd100, 8'd30,  8'h7F);
        send_packet(8'd128, 8'd68,  8'd0,   8'd0,   8'h3F);
        send_packet(8'd128, 8'd128, 8'd60,  8'd0,   8'h00);
        repeat (180) send_random();

        set_limits(7'd100, 7'd100);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        repeat (150) send_random();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        repeat (100) send_random();

        // zero limits silence every output
        set_limits(7'd0, 7'd0);
        repeat (100) send_random();

        // receiver holds off while the sender keeps offering back to back
        set_limits(7'd127, 7'd127);
        rx_hold_req = 1'b1;
        tx_quiet    = 1'b1;
        repeat (40) send_random();
        tx_quiet = 1'b0;
        repeat (160) send_random();

        set_limits(7'd1, 7'd127);
        repeat (150) send_random();
        repeat (3)
        begin
            set_limits(DutyW'($urandom_range(0, 127)), DutyW'($urandom_range(0, 127)));
            repeat (150) send_random();
        end

        drain();
        if (errors == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
rtl/mdm_pkg.sv
rtl/mecanum_drive_mixer_core.sv
test/mecanum_drive_mixer_checker.sv
test/mecanum_drive_mixer_core_tb.sv
